// File: hw/rtl/pgs_pkg.sv
// Shared types and constants for the Gauss-Seidel Poisson solver core.
// No dependencies; the front end, back end, top level and testbench take names from here by scope.
package pgs_pkg;

    // command codes on the input word
    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_RUN  = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_ACTIVE_SIZE = 2'd0;
    localparam logic [1:0] CFG_GRID_STEP   = 2'd1;
    localparam logic [1:0] CFG_TOLERANCE   = 2'd2;
    localparam logic [1:0] CFG_SWEEP_LIMIT = 2'd3;

    // configuration reset values
    localparam logic [6:0]  ACTIVE_SIZE_RST = 7'd64;
    localparam logic [24:0] GRID_STEP_RST   = 25'd169467;
    localparam logic [24:0] TOLERANCE_RST   = 25'd168;
    localparam logic [15:0] SWEEP_LIMIT_RST = 16'd65535;

    // command queue depth between front and back
    localparam int Q_DEPTH = 2;

    typedef enum logic [1:0] {
        KIND_LOAD = 2'd0,
        KIND_RUN  = 2'd1,
        KIND_READ = 2'd2,
        KIND_NOP  = 2'd3
    } kind_t;

    typedef struct packed {
        logic [6:0]  active_size;
        logic [24:0] grid_step;
        logic [24:0] tolerance;
        logic [15:0] sweep_limit;
    } cfg_t;

    typedef struct packed {
        kind_t       kind;
        logic        in_range;
        logic [5:0]  row;
        logic [5:0]  col;
        logic [31:0] value;
    } q_entry_t;

endpackage

// File: hw/rtl/pgs_front.sv
// Front end: accepts input words, classifies them and queues them for the back end.
// Depends on pgs_pkg.
module pgs_front #(
    parameter int GRID_SIDE  = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [1:0]          cmd,
    input  logic [5:0]          row,
    input  logic [5:0]          col,
    input  logic signed [31:0]  cell_value,
    output logic                q_valid,
    input  logic                q_take,
    output pgs_pkg::q_entry_t   q_entry
);

    localparam int  VB   = (VALUE_BITS > 32) ? 32 : ((VALUE_BITS < 16) ? 16 : VALUE_BITS);
    localparam longint VMAX = (64'sd1 <<< (VB - 1)) - 64'sd1;
    localparam longint VMIN = -VMAX - 64'sd1;

    localparam int Q_DEPTH_L = pgs_pkg::Q_DEPTH;
    localparam int PTR_W = (Q_DEPTH_L > 1) ? $clog2(Q_DEPTH_L) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH_L + 1);

    pgs_pkg::q_entry_t q_mem_reg [Q_DEPTH_L];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  cnt_reg;
    pgs_pkg::q_entry_t new_entry;
    logic              wr_en;
    logic              rd_en;

    // classify the incoming word
    always_comb
    begin
        new_entry.row      = row;
        new_entry.col      = col;
        new_entry.in_range = (32'(row) < 32'(GRID_SIDE)) && (32'(col) < 32'(GRID_SIDE));
        unique case (cmd)
            pgs_pkg::CMD_LOAD: new_entry.kind = pgs_pkg::KIND_LOAD;
            pgs_pkg::CMD_RUN:  new_entry.kind = pgs_pkg::KIND_RUN;
            pgs_pkg::CMD_READ: new_entry.kind = pgs_pkg::KIND_READ;
            default:           new_entry.kind = pgs_pkg::KIND_NOP;
        endcase
        // clamp the load value to the value range
        if (64'(cell_value) > VMAX)
            new_entry.value = 32'(VMAX);
        else if (64'(cell_value) < VMIN)
            new_entry.value = 32'(VMIN);
        else
            new_entry.value = cell_value;
    end

    assign full    = (cnt_reg == CNT_W'(Q_DEPTH_L));
    assign q_valid = (cnt_reg != '0);
    assign wr_en   = push && !full;
    assign rd_en   = q_take && q_valid;
    assign q_entry = q_mem_reg[rd_ptr_reg];

    // advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= (32'(wr_ptr_reg) == Q_DEPTH_L - 1) ? '0 : wr_ptr_reg + 1'b1;
            if (rd_en)
                rd_ptr_reg <= (32'(rd_ptr_reg) == Q_DEPTH_L - 1) ? '0 : rd_ptr_reg + 1'b1;
            if (wr_en && !rd_en)
                cnt_reg <= cnt_reg + 1'b1;
            else if (rd_en && !wr_en)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // hold queued words
    always_ff @(posedge clk)
    begin
        if (wr_en)
            q_mem_reg[wr_ptr_reg] <= new_entry;
    end

endmodule

// File: hw/rtl/pgs_back.sv
// Back end: grid memory, load/read execution and the Gauss-Seidel sweep sequencer.
// Depends on pgs_pkg.
module pgs_back #(
    parameter int GRID_SIDE  = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  pgs_pkg::cfg_t       cfg,
    input  logic                q_valid,
    output logic                q_take,
    input  pgs_pkg::q_entry_t   q_entry,
    output logic                empty,
    input  logic                pop,
    output logic signed [31:0]  read_value,
    output logic [15:0]         sweeps_done,
    output logic                converged,
    output logic [30:0]         final_change
);

    localparam int DEPTH  = GRID_SIDE * GRID_SIDE;
    localparam int AW     = $clog2(DEPTH);
    localparam int IDX_W  = $clog2(GRID_SIDE);
    localparam int H2_W   = 50;
    localparam int S_W    = H2_W + 2 * IDX_W;
    localparam int HSQ_W  = 27;
    localparam int SRC_W  = 31;
    localparam int TERM_W = 34;
    localparam int SUM_W  = 38;
    localparam int VB     = (VALUE_BITS > 32) ? 32 : ((VALUE_BITS < 16) ? 16 : VALUE_BITS);
    localparam longint VMAX = (64'sd1 <<< (VB - 1)) - 64'sd1;
    localparam longint VMIN = -VMAX - 64'sd1;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_READ  = 9'b000000010,
        ST_SETUP = 9'b000000100,
        ST_INIT  = 9'b000001000,
        ST_RD0   = 9'b000010000,
        ST_RD1   = 9'b000100000,
        ST_RD2   = 9'b001000000,
        ST_CALC  = 9'b010000000,
        ST_SWEND = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    // grid memory and its ports
    logic [31:0]  mem [DEPTH];
    logic [31:0]  rd_a_reg, rd_b_reg;
    logic [AW-1:0] ra, rb, wa;
    logic [31:0]  wd;
    logic         we;

    // sweep datapath
    logic [IDX_W-1:0]         i_reg, j_reg, last_reg;
    logic [AW-1:0]            k_reg, step_reg;
    logic [H2_W-1:0]          h2_reg;
    logic [HSQ_W-1:0]         hsq_reg;
    logic [S_W-1:0]           r_reg, s_reg;
    logic [SRC_W-1:0]         src_reg;
    logic [TERM_W-1:0]        term_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [31:0]       old_reg;
    logic [32:0]              maxc_reg;
    logic [15:0]              run_cnt_reg, limit_reg;
    logic                     in_range_reg;

    // result and status
    logic                     out_valid_reg;
    logic signed [31:0]       rv_reg;
    logic [15:0]              sweeps_reg;
    logic                     conv_reg;
    logic [30:0]              change_reg;

    logic                     slot_free;
    logic [AW-1:0]            cmd_addr;
    logic [S_W:0]             s_rnd;
    logic [SRC_W-1:0]         src_next;
    logic [57:0]              prod;
    logic [58:0]              prod_rnd;
    logic signed [SUM_W-1:0]  total, quarter;
    logic signed [31:0]       nv;
    logic signed [32:0]       diff;
    logic [32:0]              adiff;
    logic [30:0]              maxc_sat;
    logic [16:0]              cnt_inc;
    logic                     more;
    logic                     row_end, grid_end;
    logic [31:0]              n_full;
    logic [S_W-1:0]           r_step;
    logic                     produce;

    assign slot_free = !out_valid_reg || pop;
    assign q_take    = (state_reg == ST_IDLE) && q_valid && slot_free;
    assign cmd_addr  = AW'(32'(q_entry.row) * 32'(GRID_SIDE) + 32'(q_entry.col));

    // source term and stencil arithmetic
    always_comb
    begin
        s_rnd    = {1'b0, s_reg} + (S_W+1)'(1 << 23);
        if (s_rnd[S_W:24] > (S_W-23)'(32'h7FFFFFFF))
            src_next = 31'h7FFFFFFF;
        else
            src_next = SRC_W'(s_rnd[S_W:24]);
        prod     = 58'(hsq_reg) * 58'(src_reg);
        prod_rnd = {1'b0, prod} + 59'(1 << 23);
        total    = sum_reg + SUM_W'($signed(rd_a_reg))
                 - $signed({{(SUM_W-TERM_W){1'b0}}, term_reg});
        quarter  = (total + SUM_W'(2)) >>> 2;
        if (quarter > SUM_W'(VMAX))
            nv = 32'(VMAX);
        else if (quarter < SUM_W'(VMIN))
            nv = 32'(VMIN);
        else
            nv = 32'(quarter);
        diff     = 33'(old_reg) - 33'(nv);
        adiff    = diff[32] ? 33'(-diff) : 33'(diff);
        maxc_sat = (maxc_reg > 33'h07FFFFFFF) ? 31'h7FFFFFFF : maxc_reg[30:0];
        cnt_inc  = 17'(run_cnt_reg) + 17'd1;
        more     = (maxc_sat > {6'b0, cfg.tolerance}) && (cnt_inc < 17'(limit_reg));
        row_end  = (j_reg == last_reg);
        grid_end = row_end && (i_reg == last_reg);
        r_step   = r_reg + S_W'(h2_reg);
        n_full   = 32'(cfg.active_size);
        if (n_full < 32'd3)
            n_full = 32'd3;
        else if (n_full > 32'(GRID_SIDE))
            n_full = 32'(GRID_SIDE);
    end

    // memory port selection
    always_comb
    begin
        ra = cmd_addr;
        rb = k_reg;
        wa = cmd_addr;
        wd = q_entry.value;
        we = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                we = q_take && (q_entry.kind == pgs_pkg::KIND_LOAD) && q_entry.in_range;
            end
            ST_RD0:
            begin
                ra = k_reg - AW'(GRID_SIDE);
                rb = k_reg;
            end
            ST_RD1:
            begin
                ra = k_reg + AW'(GRID_SIDE);
                rb = k_reg - AW'(1);
            end
            ST_RD2:
            begin
                ra = k_reg + AW'(1);
            end
            ST_CALC:
            begin
                wa = k_reg;
                wd = nv;
                we = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // sequence commands and sweeps
    always_comb
    begin
        state_next = state_reg;
        produce    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_take)
                begin
                    case (q_entry.kind)
                        pgs_pkg::KIND_READ: state_next = ST_READ;
                        pgs_pkg::KIND_RUN:  state_next = ST_SETUP;
                        default:            produce    = 1'b1;
                    endcase
                end
            end
            ST_READ:
            begin
                produce    = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SETUP: state_next = ST_INIT;
            ST_INIT:  state_next = ST_RD0;
            ST_RD0:   state_next = ST_RD1;
            ST_RD1:   state_next = ST_RD2;
            ST_RD2:   state_next = ST_CALC;
            ST_CALC:  state_next = grid_end ? ST_SWEND : ST_RD0;
            ST_SWEND:
            begin
                if (more)
                    state_next = ST_INIT;
                else
                begin
                    produce    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // control state, result slot and status
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            sweeps_reg    <= '0;
            conv_reg      <= 1'b0;
            change_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (produce)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;
            if (state_reg == ST_SWEND && !more)
            begin
                sweeps_reg <= cnt_inc[15:0];
                conv_reg   <= (maxc_sat <= {6'b0, cfg.tolerance});
                change_reg <= maxc_sat;
            end
        end
    end

    // hold the sweep datapath and read word
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_take)
                begin
                    rv_reg       <= '0;
                    in_range_reg <= q_entry.in_range;
                end
            end
            ST_READ:
            begin
                rv_reg <= in_range_reg ? rd_a_reg : '0;
            end
            ST_SETUP:
            begin
                h2_reg      <= 50'(cfg.grid_step) * 50'(cfg.grid_step);
                run_cnt_reg <= '0;
                last_reg    <= IDX_W'(n_full - 32'd2);
                step_reg    <= AW'(32'(GRID_SIDE) + 32'd3 - n_full);
                limit_reg   <= (cfg.sweep_limit == '0) ? 16'd1 : cfg.sweep_limit;
            end
            ST_INIT:
            begin
                hsq_reg  <= HSQ_W'((51'(h2_reg) + 51'(1 << 23)) >> 24);
                r_reg    <= S_W'(h2_reg);
                s_reg    <= S_W'(h2_reg);
                i_reg    <= IDX_W'(1);
                j_reg    <= IDX_W'(1);
                k_reg    <= AW'(GRID_SIDE + 1);
                maxc_reg <= '0;
            end
            ST_RD0:
            begin
                src_reg <= src_next;
            end
            ST_RD1:
            begin
                sum_reg  <= SUM_W'($signed(rd_a_reg));
                old_reg  <= rd_b_reg;
                term_reg <= TERM_W'(prod_rnd[58:24]);
            end
            ST_RD2:
            begin
                sum_reg <= sum_reg + SUM_W'($signed(rd_a_reg)) + SUM_W'($signed(rd_b_reg));
            end
            ST_CALC:
            begin
                if (adiff > maxc_reg)
                    maxc_reg <= adiff;
                if (row_end)
                begin
                    i_reg <= i_reg + IDX_W'(1);
                    j_reg <= IDX_W'(1);
                    k_reg <= k_reg + step_reg;
                    r_reg <= r_step;
                    s_reg <= r_step;
                end
                else
                begin
                    j_reg <= j_reg + IDX_W'(1);
                    k_reg <= k_reg + AW'(1);
                    s_reg <= s_reg + r_reg;
                end
            end
            ST_SWEND:
            begin
                run_cnt_reg <= cnt_inc[15:0];
            end
            default:
            begin
            end
        endcase
    end

    // grid memory
    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= wd;
        rd_a_reg <= mem[ra];
        rd_b_reg <= mem[rb];
    end

    assign empty        = !out_valid_reg;
    assign read_value   = rv_reg;
    assign sweeps_done  = sweeps_reg;
    assign converged    = conv_reg;
    assign final_change = change_reg;

endmodule

// File: hw/rtl/poisson_gauss_seidel_solver_core.sv
// Top level of the Gauss-Seidel Poisson solver: configuration registers,
// front end queue and back end sequencer. Depends on pgs_pkg, pgs_front, pgs_back.
//
// Words enter through push/full and results leave through empty/pop; every
// word gives exactly one result. The back end takes a new word only when idle
// with its result slot free. A read passes through ST_READ; a run passes
// through ST_SETUP and, for each sweep, ST_INIT, the cell states and ST_SWEND.
// Each interior cell steps through ST_RD0, ST_RD1, ST_RD2 and ST_CALC because
// its five stencil words come through the grid memory's two read ports. The grid
// memory is not cleared after reset; every cell must be loaded before it is
// read or swept. The status fields always show the last run.
module poisson_gauss_seidel_solver_core #(
    parameter int GRID_SIDE  = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [1:0]          cmd,
    input  logic [5:0]          row,
    input  logic [5:0]          col,
    input  logic signed [31:0]  cell_value,
    output logic                empty,
    input  logic                pop,
    output logic signed [31:0]  read_value,
    output logic [15:0]         sweeps_done,
    output logic                converged,
    output logic [30:0]         final_change,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [24:0]         cfg_data
);

    pgs_pkg::cfg_t     cfg_reg;
    pgs_pkg::q_entry_t q_entry;
    logic              q_valid;
    logic              q_take;

    assign cfg_ready = 1'b1;

    // write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.active_size <= pgs_pkg::ACTIVE_SIZE_RST;
            cfg_reg.grid_step   <= pgs_pkg::GRID_STEP_RST;
            cfg_reg.tolerance   <= pgs_pkg::TOLERANCE_RST;
            cfg_reg.sweep_limit <= pgs_pkg::SWEEP_LIMIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                pgs_pkg::CFG_ACTIVE_SIZE: cfg_reg.active_size <= cfg_data[6:0];
                pgs_pkg::CFG_GRID_STEP:   cfg_reg.grid_step   <= cfg_data;
                pgs_pkg::CFG_TOLERANCE:   cfg_reg.tolerance   <= cfg_data;
                pgs_pkg::CFG_SWEEP_LIMIT: cfg_reg.sweep_limit <= cfg_data[15:0];
                default:                  cfg_reg.active_size <= cfg_reg.active_size;
            endcase
        end
    end

    pgs_front #(
        .GRID_SIDE  (GRID_SIDE),
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .cmd        (cmd),
        .row        (row),
        .col        (col),
        .cell_value (cell_value),
        .q_valid    (q_valid),
        .q_take     (q_take),
        .q_entry    (q_entry)
    );

    pgs_back #(
        .GRID_SIDE  (GRID_SIDE),
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_valid      (q_valid),
        .q_take       (q_take),
        .q_entry      (q_entry),
        .empty        (empty),
        .pop          (pop),
        .read_value   (read_value),
        .sweeps_done  (sweeps_done),
        .converged    (converged),
        .final_change (final_change)
    );

endmodule

// File: hw/rtl/pgs_checker.sv
// Port-level checks for the solver core, attached by bind.
// Depends on poisson_gauss_seidel_solver_core.
module pgs_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                push,
    input logic                full,
    input logic                pop,
    input logic                empty,
    input logic signed [31:0]  read_value,
    input logic [15:0]         sweeps_done,
    input logic                converged,
    input logic [30:0]         final_change
);

    logic [3:0] pending_reg;

    // count words accepted but not yet answered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else
            pending_reg <= pending_reg + 4'(push && !full) - 4'(pop && !empty);
    end

    // no result without an outstanding word
    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        (pending_reg == 4'd0) |-> empty)
        else $error("result shown with no word outstanding");

    // a converged run performed at least one sweep
    a_conv_sweeps: assert property (@(posedge clk) disable iff (!rst_n)
        converged |-> (sweeps_done != 16'd0))
        else $error("converged flag with zero sweeps");

    // a waiting word holds its read value
    a_hold_value: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> $stable(read_value))
        else $error("read value changed while waiting");

    // status holds while a result waits
    a_hold_status: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> ($stable(sweeps_done) && $stable(converged)
                              && $stable(final_change)))
        else $error("status changed while a result waits");

endmodule

bind poisson_gauss_seidel_solver_core pgs_checker u_pgs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .pop          (pop),
    .empty        (empty),
    .read_value   (read_value),
    .sweeps_done  (sweeps_done),
    .converged    (converged),
    .final_change (final_change)
);

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for poisson_gauss_seidel_solver_core: a local
// Gauss-Seidel predictor checks every result word. Depends on pgs_pkg.
module testbench;

    localparam int SIDE = 64;
    localparam int REGION = 12;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int RANDOM_WORDS = 1430;
    localparam longint unsigned SAT31 = 64'h7FFF_FFFF;

    typedef struct {
        logic signed [31:0] read_value;
        logic [15:0]        sweeps;
        logic               conv;
        logic [30:0]        change;
    } status_t;

    logic               clk;
    logic               rst_n;
    logic               push;
    logic               full;
    logic [1:0]         cmd;
    logic [5:0]         row;
    logic [5:0]         col;
    logic signed [31:0] cell_value;
    logic               empty;
    logic               pop;
    logic signed [31:0] read_value;
    logic [15:0]        sweeps_done;
    logic               converged;
    logic [30:0]        final_change;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [24:0]         cfg_data;

    poisson_gauss_seidel_solver_core u_dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .cmd(cmd), .row(row),
        .col(col), .cell_value(cell_value), .empty(empty), .pop(pop),
        .read_value(read_value), .sweeps_done(sweeps_done), .converged(converged),
        .final_change(final_change), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predictor state
    logic [6:0]         size_reg;
    logic [24:0]        step_reg;
    logic [24:0]        tol_reg;
    logic [15:0]        limit_reg;
    logic signed [31:0] grid_mem [0:SIDE*SIDE-1];
    bit                 loaded [0:SIDE*SIDE-1];
    logic [15:0]        last_sweeps;
    logic               last_conv;
    logic [30:0]        last_change;

    status_t            pending_status[$];
    int                 mismatches;
    int                 cycles;
    bit                 no_idle;
    bit                 hold_stall;
    int                 pop_gap;
    event               long_hold;

    // clock and cycle watchdog
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic longint unsigned q24_mul(longint unsigned a, longint unsigned b);
        return (a * b + (64'd1 << 23)) >> 24;
    endfunction

    // one in-place sweep over the interior; returns the largest change
    function automatic longint unsigned grid_sweep(int n);
        longint unsigned h, hsq, src, term, ad, maxc;
        longint signed   s, nv, old;
        int              k;
        h = step_reg;
        hsq = q24_mul(h, h);
        maxc = 0;
        for (int i = 1; i < n - 1; i++)
        begin
            for (int j = 1; j < n - 1; j++)
            begin
                k = i * SIDE + j;
                src = q24_mul(h * longint'(i), h * longint'(j));
                if (src > SAT31) src = SAT31;
                term = q24_mul(hsq, src);
                s = longint'(grid_mem[k-1]) + longint'(grid_mem[k+1])
                    + longint'(grid_mem[k+SIDE]) + longint'(grid_mem[k-SIDE]);
                s = s - longint'(term);
                nv = (s + 2) >>> 2;
                if (nv > 64'sh7FFF_FFFF) nv = 64'sh7FFF_FFFF;
                if (nv < -64'sh8000_0000) nv = -64'sh8000_0000;
                old = grid_mem[k];
                grid_mem[k] = nv[31:0];
                ad = (old > nv) ? longint'(old - nv) : longint'(nv - old);
                if (ad > maxc) maxc = ad;
            end
        end
        if (maxc > SAT31) maxc = SAT31;
        return maxc;
    endfunction

    function automatic void solve_grid();
        int              n;
        int              lim;
        int              count;
        longint unsigned maxc;
        n = size_reg;
        if (n < 3) n = 3;
        if (n > SIDE) n = SIDE;
        lim = (limit_reg == 0) ? 1 : limit_reg;
        count = 0;
        do
        begin
            maxc = grid_sweep(n);
            count++;
        end while (maxc > tol_reg && count < lim);
        last_sweeps = count[15:0];
        last_conv = (maxc <= tol_reg);
        last_change = maxc[30:0];
    endfunction

    function automatic status_t predict_word(logic [1:0] c, logic [5:0] r, logic [5:0] cl,
                                             logic signed [31:0] v);
        status_t st;
        int      k;
        k = r * SIDE + cl;
        st.read_value = '0;
        case (c)
            pgs_pkg::CMD_LOAD:
            begin
                grid_mem[k] = v;
                loaded[k] = 1'b1;
            end
            pgs_pkg::CMD_RUN:  solve_grid();
            pgs_pkg::CMD_READ: st.read_value = grid_mem[k];
            default: ;
        endcase
        st.sweeps = last_sweeps;
        st.conv = last_conv;
        st.change = last_change;
        return st;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("[%0t] %s: got %0h want %0h", $time, what, got, want);
        mismatches++;
    endtask

    // pop side: random stalls, plus a long hold on request
    initial
    begin
        hold_stall = 1'b0;
        forever
        begin
            @(long_hold);
            hold_stall = 1'b1;
            repeat (400) @(posedge clk);
            hold_stall = 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (pending_status.size() == 0)
                    report("result word with nothing expected", read_value, 0);
                else
                begin
                    status_t want;
                    want = pending_status.pop_front();
                    if (read_value !== want.read_value)
                        report("read_value", read_value, want.read_value);
                    if (sweeps_done !== want.sweeps)
                        report("sweeps_done", sweeps_done, want.sweeps);
                    if (converged !== want.conv)
                        report("converged", converged, want.conv);
                    if (final_change !== want.change)
                        report("final_change", final_change, want.change);
                end
                pop_gap = pick_gap();
            end
            if (pop_gap > 0 && !(pop && !empty))
                pop_gap--;
            pop <= !hold_stall && pop_gap == 0;
        end
    end

    // send one input word; push stays high afterwards until the next idle
    task automatic send_word(logic [1:0] c, logic [5:0] r, logic [5:0] cl,
                             logic signed [31:0] v);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        cmd <= c;
        row <= r;
        col <= cl;
        cell_value <= v;
        do @(posedge clk); while (full);
        pending_status.push_back(predict_word(c, r, cl, v));
    endtask

    // drop push and wait for every result word to come back
    task automatic drain_results();
        push <= 1'b0;
        wait (pending_status.size() == 0);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_config(logic [6:0] sz, logic [24:0] h, logic [24:0] tol,
                                logic [15:0] lim);
        logic [24:0] vals [4];
        vals[pgs_pkg::CFG_ACTIVE_SIZE] = {18'd0, sz};
        vals[pgs_pkg::CFG_GRID_STEP] = h;
        vals[pgs_pkg::CFG_TOLERANCE] = tol;
        vals[pgs_pkg::CFG_SWEEP_LIMIT] = {9'd0, lim};
        drain_results();
        for (int i = 0; i < 4; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= 2'(i);
            cfg_data <= vals[i];
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        size_reg = sz;
        step_reg = h;
        tol_reg = tol;
        limit_reg = lim;
    endtask

    function automatic logic signed [31:0] rand_cell();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return $signed(25'($urandom()));
            default: return $signed(27'($urandom()));
        endcase
    endfunction

    // load every cell of an n-by-n corner
    task automatic load_region(int n, bit zeros);
        for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++)
                send_word(pgs_pkg::CMD_LOAD, 6'(r), 6'(c), zeros ? 32'sd0 : rand_cell());
    endtask

    task automatic read_some(int count);
        int k;
        for (int i = 0; i < count; i++)
        begin
            do k = $urandom_range(0, SIDE*SIDE-1); while (!loaded[k]);
            send_word(pgs_pkg::CMD_READ, 6'(k / SIDE), 6'(k % SIDE), $urandom());
        end
    endtask

    // field extremes, unused command, corner addresses
    task automatic test_corners();
        no_idle = 1'b0;
        send_word(pgs_pkg::KIND_NOP, 6'd63, 6'd63, 32'sh7FFF_FFFF);
        send_word(pgs_pkg::CMD_LOAD, 6'd0, 6'd0, 32'sh8000_0000);
        send_word(pgs_pkg::CMD_LOAD, 6'd63, 6'd63, 32'sh7FFF_FFFF);
        send_word(pgs_pkg::CMD_LOAD, 6'd0, 6'd63, 32'sh0000_0000);
        send_word(pgs_pkg::CMD_LOAD, 6'd63, 6'd0, 32'shFFFF_FFFF);
        send_word(pgs_pkg::CMD_READ, 6'd0, 6'd0, 32'sh7FFF_FFFF);
        send_word(pgs_pkg::CMD_READ, 6'd63, 6'd63, 32'sh8000_0000);
        send_word(pgs_pkg::CMD_READ, 6'd0, 6'd63, 32'sh0);
        send_word(pgs_pkg::CMD_READ, 6'd63, 6'd0, 32'sh0);
    endtask

    // load the corner every later grid uses and sweep it; sweep limit zero acts as one
    task automatic test_region_grid();
        no_idle = 1'b1;
        write_config(7'(REGION), 25'd169467, 25'd0, 16'd0);
        load_region(REGION, 1'b0);
        send_word(pgs_pkg::CMD_RUN, 6'd0, 6'd0, 32'sh0);
        read_some(8);
    endtask

    // undersize grid acts as three; largest step, zero tolerance
    task automatic test_tiny_grid();
        no_idle = 1'b0;
        write_config(7'd0, 25'h1FF_FFFF, 25'd0, 16'd3);
        send_word(pgs_pkg::CMD_RUN, 6'd0, 6'd0, 32'sh0);
        send_word(pgs_pkg::CMD_READ, 6'd1, 6'd1, 32'sh0);
        write_config(7'd3, 25'd16777216, 25'h1FF_FFFF, 16'd2);
        send_word(pgs_pkg::CMD_RUN, 6'd0, 6'd0, 32'sh0);
    endtask

    // zero grid with zero step settles in one sweep under the largest limit
    task automatic test_settled_grid();
        write_config(7'd4, 25'd0, 25'h1FF_FFFF, 16'd65535);
        load_region(4, 1'b1);
        send_word(pgs_pkg::CMD_RUN, 6'd0, 6'd0, 32'sh0);
        send_word(pgs_pkg::CMD_READ, 6'd2, 6'd2, 32'sh0);
    endtask

    // fill the block while pop is held, then pause until all come back
    task automatic test_backpressure();
        no_idle = 1'b1;
        drain_results();
        -> long_hold;
        for (int i = 0; i < 40; i++)
            send_word(i % 2 ? pgs_pkg::CMD_READ : pgs_pkg::CMD_LOAD,
                      6'($urandom_range(0, REGION-1)), 6'($urandom_range(0, REGION-1)),
                      rand_cell());
        drain_results();
        no_idle = 1'b0;
    endtask

    // configure, load a small grid, solve, then read back with noise
    task automatic test_random();
        int sent;
        int n;
        int lim;
        logic [24:0] h;
        logic [24:0] tol;
        sent = 0;
        while (sent < RANDOM_WORDS)
        begin
            no_idle = ($urandom_range(0, 4) == 0);
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, REGION) : $urandom_range(3, 8);
            lim = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 10);
            h = ($urandom_range(0, 3) == 0) ? 25'($urandom()) : 25'($urandom_range(0, 1 << 22));
            case ($urandom_range(0, 3))
                0: tol = 25'($urandom());
                1: tol = 25'($urandom_range(0, 255));
                default: tol = 25'($urandom_range(0, 1 << 20));
            endcase
            write_config(7'(n), h, tol, 16'(lim));
            if (n < 3) n = 3;
            if ($urandom_range(0, 1))
            begin
                load_region(n, 1'b0);
                sent += n * n;
            end
            else
            begin
                for (int i = 0; i < n; i++)
                    send_word(pgs_pkg::CMD_LOAD, 6'($urandom_range(0, n-1)),
                              6'($urandom_range(0, n-1)), rand_cell());
                sent += n;
            end
            send_word(pgs_pkg::CMD_RUN, 6'($urandom()), 6'($urandom()), $urandom());
            read_some($urandom_range(2, 8));
            if ($urandom_range(0, 2) == 0)
                send_word(pgs_pkg::KIND_NOP, 6'($urandom()), 6'($urandom()), $urandom());
            if ($urandom_range(0, 3) == 0)
                send_word(pgs_pkg::CMD_RUN, 6'($urandom()), 6'($urandom()), $urandom());
            sent += 8;
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        cmd = pgs_pkg::CMD_LOAD;
        row = '0;
        col = '0;
        cell_value = '0;
        pop = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = pgs_pkg::CFG_ACTIVE_SIZE;
        cfg_data = '0;
        cycles = 0;
        mismatches = 0;
        pop_gap = 0;
        no_idle = 1'b0;
        size_reg = pgs_pkg::ACTIVE_SIZE_RST;
        step_reg = pgs_pkg::GRID_STEP_RST;
        tol_reg = pgs_pkg::TOLERANCE_RST;
        limit_reg = pgs_pkg::SWEEP_LIMIT_RST;
        last_sweeps = '0;
        last_conv = 1'b0;
        last_change = '0;
        for (int k = 0; k < SIDE*SIDE; k++)
        begin
            grid_mem[k] = '0;
            loaded[k] = 1'b0;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_corners();
        test_region_grid();
        test_tiny_grid();
        test_settled_grid();
        test_backpressure();
        test_random();

        drain_results();
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
